// ===== rtl/core/crps_pkg.sv =====
// Shared widths, types, state codes and weight and divisor functions for the Catmull-Rom path sampler.
`timescale 1ns / 1ps

package crps_pkg;

  localparam int COORD_W       = 32;
  localparam int WT_W          = 24;             // blend weight, covers steps up to 63
  localparam int NUM_W         = 60;             // 2*sum(w*p) + d
  localparam int DIV_W         = 21;             // 4*s^3
  localparam int DIFF_W        = COORD_W + 1;
  localparam int SQ_W          = 2 * DIFF_W;
  localparam int SUM_W         = SQ_W + 2;
  localparam int ROOT_W        = SUM_W / 2;
  localparam int LEN_W         = 32;
  localparam int STEPS_W       = 4;
  localparam int CFG_AW        = 2;
  localparam int DEF_MAX_STEPS = 15;

  localparam logic [STEPS_W-1:0] STEPS_RESET = 4'd3;
  localparam logic [CFG_AW-1:0]  ADDR_STEPS  = 2'd0;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WT_W-1:0]    weight_t;

  typedef enum logic [2:0] {
    L_IDLE, L_MAC, L_PREP, L_DIV, L_FIN
  } lane_state_e;

  typedef enum logic [1:0] {
    M_IDLE, M_SQ, M_ROOT, M_FIN
  } merge_state_e;

  typedef enum logic [2:0] {
    T_IDLE, T_WGT, T_LANE, T_MERGE, T_OUT
  } top_state_e;

  // Weight k of the uniform Catmull-Rom basis at u = i/s, scaled by 2*s^3.
  function automatic weight_t crps_weight(input int i, input int s, input logic [1:0] k);
    int i2;
    int i3;
    int s2;
    int s3;
    int w;
    i2 = i * i;
    i3 = i2 * i;
    s2 = s * s;
    s3 = s2 * s;
    case (k)
      2'd0:    w = -i3 + 2 * i2 * s - i * s2;
      2'd1:    w = 3 * i3 - 5 * i2 * s + 2 * s3;
      2'd2:    w = -3 * i3 + 4 * i2 * s + i * s2;
      default: w = i3 - i2 * s;
    endcase
    return WT_W'(w);
  endfunction

  function automatic logic [DIV_W-1:0] crps_divisor(input int s);
    return DIV_W'(4 * s * s * s);
  endfunction

endpackage

// ===== rtl/core/catmull_rom_path_sampler.sv =====
// Top level: waypoint window, node sequencer, three coordinate lanes, merge stage, ports.
`timescale 1ns / 1ps

// Keeps the last four waypoints; from the fourth one on, each waypoint yields steps+1 nodes of
// the Catmull-Rom segment between the middle two points (a steps of zero counts as one, and
// steps is capped at MAX_STEPS), the last with tlast set, each with its running path length.
// For each node the x, y and z lanes run side by side, each with four multiply-accumulates
// and a 60-step restoring divider, and the merge stage then sums three squares and runs a
// 34-step integer root. The first node after reset or a clear skips the squares and the root.
// A clear or a word that leaves fewer than four waypoints in the window starts no segment.
// The next word is taken once the segment is done, while the last node may still wait.
module catmull_rom_path_sampler
  import crps_pkg::*;
#(
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB-style configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // waypoint stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [95:0]         s_axis_tdata,   // point_x, point_y, point_z
  input  logic                s_axis_tuser,   // command
  // node stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [127:0]        m_axis_tdata,   // node_x, node_y, node_z, path_length
  output logic                m_axis_tlast    // last_node
);

  localparam int SW = $clog2(MAX_STEPS + 1);

  top_state_e state_q, state_d;

  logic [STEPS_W-1:0] steps_q;
  coord_t             win_x_q [4];
  coord_t             win_y_q [4];
  coord_t             win_z_q [4];
  logic [2:0]         count_q;
  logic [SW-1:0]      i_q;
  logic [SW-1:0]      s_q;
  logic [SW-1:0]      s_clamp;
  weight_t            wts [4];
  logic [DIV_W-1:0]   divisor;
  logic               in_fire;
  logic               seg_start;
  logic               lane_start;
  logic               lane_done;
  logic               done_x;
  logic               done_y;
  logic               done_z;
  coord_t             nodes [3];
  logic               merge_start;
  logic               merge_done;
  logic               merge_clear;
  logic [LEN_W-1:0]   length;
  logic               out_free;
  logic               valid_q;
  logic [127:0]       data_q;
  logic               last_q;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_STEPS) ? {{(32-STEPS_W){1'b0}}, steps_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= STEPS_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_STEPS) begin
      steps_q <= pwdata[STEPS_W-1:0];
    end
  end

  always_comb begin
    if (steps_q == '0) s_clamp = SW'(1);
    else if (int'(steps_q) > MAX_STEPS) s_clamp = SW'(MAX_STEPS);
    else s_clamp = SW'(steps_q);
  end

  for (genvar k = 0; k < 4; k++) begin : g_wt
    assign wts[k] = crps_weight(int'(i_q), int'(s_q), 2'(k));
  end
  assign divisor = crps_divisor(int'(s_q));

  assign s_axis_tready = (state_q == T_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign seg_start     = in_fire && !s_axis_tuser && (count_q >= 3'd3);
  assign merge_clear   = in_fire && s_axis_tuser;
  assign lane_start    = (state_q == T_WGT);
  assign lane_done     = done_x && done_y && done_z;
  assign merge_start   = (state_q == T_LANE) && lane_done;
  assign out_free      = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        if (s_axis_tuser) count_q <= '0;
        else if (count_q != 3'd4) count_q <= count_q + 3'd1;
      end
      if (state_q == T_OUT && out_free) valid_q <= 1'b1;
      else if (m_axis_tready) valid_q <= 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE:  if (seg_start) state_d = T_WGT;
      T_WGT:   state_d = T_LANE;
      T_LANE:  if (lane_done) state_d = T_MERGE;
      T_MERGE: if (merge_done) state_d = T_OUT;
      T_OUT: begin
        if (out_free) state_d = (i_q == s_q) ? T_IDLE : T_WGT;
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !s_axis_tuser) begin
      win_x_q <= '{win_x_q[1], win_x_q[2], win_x_q[3], s_axis_tdata[31:0]};
      win_y_q <= '{win_y_q[1], win_y_q[2], win_y_q[3], s_axis_tdata[63:32]};
      win_z_q <= '{win_z_q[1], win_z_q[2], win_z_q[3], s_axis_tdata[95:64]};
    end
    if (seg_start) begin
      i_q <= '0;
      s_q <= s_clamp;
    end else if (state_q == T_OUT && out_free) begin
      i_q <= i_q + SW'(1);
    end
    if (state_q == T_OUT && out_free) begin
      data_q <= {length, nodes[2], nodes[1], nodes[0]};
      last_q <= (i_q == s_q);
    end
  end

  crps_lane u_lane_x (
    .clk_i, .rst_ni, .start_i(lane_start), .weight_i(wts), .point_i(win_x_q),
    .divisor_i(divisor), .done_o(done_x), .node_o(nodes[0])
  );

  crps_lane u_lane_y (
    .clk_i, .rst_ni, .start_i(lane_start), .weight_i(wts), .point_i(win_y_q),
    .divisor_i(divisor), .done_o(done_y), .node_o(nodes[1])
  );

  crps_lane u_lane_z (
    .clk_i, .rst_ni, .start_i(lane_start), .weight_i(wts), .point_i(win_z_q),
    .divisor_i(divisor), .done_o(done_z), .node_o(nodes[2])
  );

  crps_merge u_merge (
    .clk_i, .rst_ni, .start_i(merge_start), .clear_i(merge_clear), .node_i(nodes),
    .done_o(merge_done), .length_o(length)
  );

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

endmodule

// ===== rtl/core/crps_lane.sv =====
// One coordinate lane: weighted sum of four points, then rounded division and saturation.
`timescale 1ns / 1ps

module crps_lane
  import crps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  weight_t          weight_i [4],
  input  coord_t           point_i [4],
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output coord_t           node_o
);

  localparam int CNT_W = $clog2(NUM_W);

  lane_state_e state_q, state_d;

  weight_t                  w_q [4];
  coord_t                   p_q [4];
  logic [DIV_W-1:0]         div_q;
  logic signed [NUM_W-1:0]  acc_q;
  logic signed [NUM_W-1:0]  num;
  logic [1:0]               k_q;
  logic                     neg_q;
  logic [NUM_W-1:0]         quo_q;
  logic [DIV_W:0]           rem_q;
  logic [DIV_W:0]           rem_sh;
  logic [DIV_W:0]           rem_sub;
  logic                     ge;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [WT_W+COORD_W-1:0] prod;
  logic [NUM_W:0]           qmag;
  logic signed [NUM_W:0]    quot;
  logic                     fits;
  coord_t                   sat;
  logic                     done_q;
  coord_t                   node_q;

  assign prod = w_q[k_q] * p_q[k_q];
  // 2n + d with d = divisor/2
  assign num  = (acc_q <<< 1)
              + $signed({{(NUM_W-DIV_W+1){1'b0}}, div_q[DIV_W-1:1]});

  assign rem_sh  = {rem_q[DIV_W-1:0], quo_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  // floor division: a negative quotient with remainder steps one further down
  assign qmag = {1'b0, quo_q} + (NUM_W+1)'(neg_q && (rem_q != '0));
  assign quot = neg_q ? -$signed(qmag) : $signed(qmag);
  assign fits = (quot[NUM_W:COORD_W-1] == '0) || (quot[NUM_W:COORD_W-1] == '1);
  assign sat  = fits ? quot[COORD_W-1:0]
              : (quot[NUM_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == L_FIN);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE: if (start_i) state_d = L_MAC;
      L_MAC:  if (k_q == 2'd3) state_d = L_PREP;
      L_PREP: state_d = L_DIV;
      L_DIV:  if (cnt_q == CNT_W'(NUM_W - 1)) state_d = L_FIN;
      L_FIN:  state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          w_q   <= weight_i;
          p_q   <= point_i;
          div_q <= divisor_i;
          acc_q <= '0;
          k_q   <= '0;
        end
      end
      L_MAC: begin
        acc_q <= acc_q + NUM_W'(prod);
        k_q   <= k_q + 2'd1;
      end
      L_PREP: begin
        neg_q <= num[NUM_W-1];
        quo_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        rem_q <= '0;
        cnt_q <= '0;
      end
      L_DIV: begin
        quo_q <= {quo_q[NUM_W-2:0], ge};
        rem_q <= ge ? rem_sub : rem_sh;
        cnt_q <= cnt_q + CNT_W'(1);
      end
      L_FIN: node_q <= sat;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign node_o = node_q;

endmodule

// ===== rtl/core/crps_merge.sv =====
// Merge stage: distance from the previous node by sum of squares and integer root, running length.
`timescale 1ns / 1ps

module crps_merge
  import crps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             clear_i,
  input  coord_t           node_i [3],
  output logic             done_o,
  output logic [LEN_W-1:0] length_o
);

  localparam int CNT_W = $clog2(ROOT_W);

  merge_state_e state_q, state_d;

  coord_t                   prev_q [3];
  logic                     seen_q;
  logic [LEN_W-1:0]         len_q;
  logic [1:0]               k_q;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic [SQ_W-1:0]          sq;
  logic [SUM_W-1:0]         rad_q;
  logic [ROOT_W+1:0]        rem_q;
  logic [ROOT_W+1:0]        r2;
  logic [ROOT_W+1:0]        trial;
  logic                     ge;
  logic [ROOT_W-1:0]        root_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [ROOT_W:0]          sum;
  logic                     done_q;

  assign diff = DIFF_W'(node_i[k_q]) - DIFF_W'(prev_q[k_q]);
  assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign sq   = mag * mag;

  assign r2    = {rem_q[ROOT_W-1:0], rad_q[SUM_W-1 -: 2]};
  assign trial = {root_q, 2'b01};
  assign ge    = r2 >= trial;

  assign sum = {1'b0, root_q} + (ROOT_W+1)'(len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
      seen_q  <= 1'b0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (clear_i) begin
        seen_q <= 1'b0;
        len_q  <= '0;
      end else if (state_q == M_IDLE && start_i && !seen_q) begin
        // first node after a clear starts the path at zero
        seen_q <= 1'b1;
        len_q  <= '0;
        done_q <= 1'b1;
      end else if (state_q == M_FIN) begin
        done_q <= 1'b1;
        if (sum >= (ROOT_W+1)'({LEN_W{1'b1}})) len_q <= '1;
        else len_q <= sum[LEN_W-1:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      M_IDLE: if (start_i && seen_q) state_d = M_SQ;
      M_SQ:   if (k_q == 2'd2) state_d = M_ROOT;
      M_ROOT: if (cnt_q == CNT_W'(ROOT_W - 1)) state_d = M_FIN;
      M_FIN:  state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        k_q    <= '0;
        rad_q  <= '0;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
        if (start_i && !seen_q) prev_q <= node_i;
      end
      M_SQ: begin
        rad_q <= rad_q + SUM_W'(sq);
        k_q   <= k_q + 2'd1;
      end
      M_ROOT: begin
        rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
        rem_q  <= ge ? (r2 - trial) : r2;
        root_q <= {root_q[ROOT_W-2:0], ge};
        cnt_q  <= cnt_q + CNT_W'(1);
      end
      M_FIN: prev_q <= node_i;
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign length_o = len_q;

endmodule
